/* hw/rtl/hcck_pkg.sv */
// Shared types, codes and the modulo-26 reduction for the 2x2 Hill cipher block.
// No dependencies; used by every module of the block.
`default_nettype none

package hcck_pkg;

  localparam int unsigned MODULUS    = 26;
  localparam int unsigned KEY_REGS   = 4;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned LETTER_W   = 5;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned SETTLE     = 4;

  localparam logic [IDX_W-1:0] REG_R0C0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_R0C1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_R1C0 = 3'd2;
  localparam logic [IDX_W-1:0] REG_R1C1 = 3'd3;

  localparam logic [LETTER_W-1:0] RST_R0C0 = 5'd17;
  localparam logic [LETTER_W-1:0] RST_R0C1 = 5'd14;
  localparam logic [LETTER_W-1:0] RST_R1C0 = 5'd0;
  localparam logic [LETTER_W-1:0] RST_R1C1 = 5'd3;

  localparam logic [CHAR_W-1:0] LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_Z = 8'h5a;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_KEY  = 2'd1,
    ST_BAD_CHAR = 2'd2
  } status_t;

  typedef struct packed {
    logic [LETTER_W-1:0] k00;
    logic [LETTER_W-1:0] k01;
    logic [LETTER_W-1:0] k10;
    logic [LETTER_W-1:0] k11;
    logic                admissible;
  } key_info_t;

  // Remainder by 26 of an 11-bit value, by multiplying with a scaled reciprocal.
  function automatic logic [LETTER_W-1:0] mod26(input logic [10:0] x);
    logic [22:0] prod;
    logic [10:0] qm;
    logic [10:0] r;
    prod = 23'(x) * 23'd2521;
    qm   = 11'(prod[22:16]) * 11'd26;
    r    = x - qm;
    return r[LETTER_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/hcck_key_unit.sv */
// Key registers and the pipelined derivation of K = A^3 + 2A mod 26 and key admissibility.
// Depends on hcck_pkg.
`default_nettype none

module hcck_key_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        wr_en,
  input  wire logic [hcck_pkg::IDX_W-1:0]  wr_index,
  input  wire logic [hcck_pkg::LETTER_W-1:0] wr_data,
  output hcck_pkg::key_info_t              key_info
);
  import hcck_pkg::*;

  logic [LETTER_W-1:0] a00, a01, a10, a11;

  logic [10:0] sq00_raw, sq01_raw, sq10_raw, sq11_raw;
  logic [9:0]  det_abs;
  logic        range_ok;

  logic [LETTER_W-1:0] sq00, sq01, sq10, sq11;
  logic        adm_s2;

  logic [10:0] k00_raw, k01_raw, k10_raw, k11_raw;
  logic        adm_s3;

  logic [9:0]  det_p, det_n;
  logic [LETTER_W-1:0] det_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      a00 <= RST_R0C0;
      a01 <= RST_R0C1;
      a10 <= RST_R1C0;
      a11 <= RST_R1C1;
    end else if (wr_en) begin
      case (wr_index)
        REG_R0C0: a00 <= wr_data;
        REG_R0C1: a01 <= wr_data;
        REG_R1C0: a10 <= wr_data;
        REG_R1C1: a11 <= wr_data;
        default: ;
      endcase
    end
  end

  assign det_p = 10'(a00) * 10'(a11);
  assign det_n = 10'(a01) * 10'(a10);
  assign det_r = mod26({1'b0, det_abs});

  always_ff @(posedge clk) begin
    sq00_raw <= 11'(10'(a00) * 10'(a00)) + 11'(10'(a01) * 10'(a10));
    sq01_raw <= 11'(10'(a00) * 10'(a01)) + 11'(10'(a01) * 10'(a11));
    sq10_raw <= 11'(10'(a10) * 10'(a00)) + 11'(10'(a11) * 10'(a10));
    sq11_raw <= 11'(10'(a10) * 10'(a01)) + 11'(10'(a11) * 10'(a11));
    det_abs  <= (det_p >= det_n) ? (det_p - det_n) : (det_n - det_p);
    range_ok <= (a00 < 5'd26) && (a01 < 5'd26) && (a10 < 5'd26) && (a11 < 5'd26);

    sq00   <= mod26(sq00_raw);
    sq01   <= mod26(sq01_raw);
    sq10   <= mod26(sq10_raw);
    sq11   <= mod26(sq11_raw);
    adm_s2 <= range_ok && det_abs[0] && (det_r != 5'd13) && (det_r != 5'd0);

    k00_raw <= 11'(10'(sq00) * 10'(a00)) + 11'(10'(sq01) * 10'(a10)) + 11'({a00, 1'b0});
    k01_raw <= 11'(10'(sq00) * 10'(a01)) + 11'(10'(sq01) * 10'(a11)) + 11'({a01, 1'b0});
    k10_raw <= 11'(10'(sq10) * 10'(a00)) + 11'(10'(sq11) * 10'(a10)) + 11'({a10, 1'b0});
    k11_raw <= 11'(10'(sq10) * 10'(a01)) + 11'(10'(sq11) * 10'(a11)) + 11'({a11, 1'b0});
    adm_s3  <= adm_s2;

    key_info.k00        <= mod26(k00_raw);
    key_info.k01        <= mod26(k01_raw);
    key_info.k10        <= mod26(k10_raw);
    key_info.k11        <= mod26(k11_raw);
    key_info.admissible <= adm_s3;
  end

endmodule

`default_nettype wire

/* hw/rtl/hcck_data_path.sv */
// Four-stage pipeline: letter decode, products, column sums, reduction and status.
// Depends on hcck_pkg and the key information from hcck_key_unit.
`default_nettype none

module hcck_data_path (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic [hcck_pkg::CHAR_W-1:0]  first_char,
  input  wire logic [hcck_pkg::CHAR_W-1:0]  second_char,
  input  wire hcck_pkg::key_info_t          key_info,
  output logic                              out_valid,
  output logic [hcck_pkg::CHAR_W-1:0]       first_cipher,
  output logic [hcck_pkg::CHAR_W-1:0]       second_cipher,
  output hcck_pkg::status_t                 status
);
  import hcck_pkg::*;

  logic                v1, v2, v3;
  logic [LETTER_W-1:0] p0, p1;
  logic                ok1, ok2, ok3;
  logic [9:0]          m00, m10, m01, m11;
  logic [10:0]         s0, s1;

  logic                lo0, up0, lo1, up1;
  logic [CHAR_W-1:0]   d0, d1;
  logic [LETTER_W-1:0] c0, c1;

  always_comb begin
    lo0 = (first_char >= LOWER_A) && (first_char <= LOWER_Z);
    up0 = (first_char >= UPPER_A) && (first_char <= UPPER_Z);
    lo1 = (second_char >= LOWER_A) && (second_char <= LOWER_Z);
    up1 = (second_char >= UPPER_A) && (second_char <= UPPER_Z);
    d0  = lo0 ? (first_char - LOWER_A) : (first_char - UPPER_A);
    d1  = lo1 ? (second_char - LOWER_A) : (second_char - UPPER_A);
  end

  assign c0 = mod26(s0);
  assign c1 = mod26(s1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    p0  <= d0[LETTER_W-1:0];
    p1  <= d1[LETTER_W-1:0];
    ok1 <= (lo0 || up0) && (lo1 || up1);

    m00 <= 10'(p0) * 10'(key_info.k00);
    m10 <= 10'(p1) * 10'(key_info.k10);
    m01 <= 10'(p0) * 10'(key_info.k01);
    m11 <= 10'(p1) * 10'(key_info.k11);
    ok2 <= ok1;

    s0  <= 11'(m00) + 11'(m10);
    s1  <= 11'(m01) + 11'(m11);
    ok3 <= ok2;

    if (!key_info.admissible) begin
      status        <= ST_BAD_KEY;
      first_cipher  <= '0;
      second_cipher <= '0;
    end else if (!ok3) begin
      status        <= ST_BAD_CHAR;
      first_cipher  <= '0;
      second_cipher <= '0;
    end else begin
      status        <= ST_OK;
      first_cipher  <= LOWER_A + 8'(c0);
      second_cipher <= LOWER_A + 8'(c1);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hill_cipher_2x2_cubic_key.sv */
// Top level of the 2x2 Hill cipher with effective key K = A^3 + 2A mod 26.
// Depends on hcck_pkg, hcck_key_unit and hcck_data_path.
//
// Usage: a request is taken at a rising edge where start is high and busy is
// low; it carries first_char and second_char. Its result appears on
// first_cipher, second_cipher and status for exactly one cycle with done high,
// once the request leaves the data pipeline. A new request may be taken every cycle,
// so the sustained rate is one pair per clock; the four-stage data pipeline
// sets the latency. The receiver cannot stall, so results never wait.
// Key letters are written through cfg_valid, cfg_index and cfg_data; cfg_ready
// is always high. Indexes beyond the four key registers are ignored. After a
// key write, and after reset, busy stays high while the key pipeline derives
// the effective matrix and checks admissibility. Writes are expected only
// while no request is in flight. Reset loads the default key and clears the
// pipeline valid bits.
`default_nettype none

module hill_cipher_2x2_cubic_key (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [hcck_pkg::CHAR_W-1:0]    first_char,
  input  wire logic [hcck_pkg::CHAR_W-1:0]    second_char,
  output logic                                done,
  output logic [hcck_pkg::CHAR_W-1:0]         first_cipher,
  output logic [hcck_pkg::CHAR_W-1:0]         second_cipher,
  output hcck_pkg::status_t                   status,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [hcck_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [hcck_pkg::LETTER_W-1:0]  cfg_data
);
  import hcck_pkg::*;

  key_info_t  key_info;
  logic [2:0] settle;
  logic       cfg_wr;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign busy      = (settle != 3'd0);
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= 3'(SETTLE);
    end else if (cfg_wr) begin
      settle <= 3'(SETTLE);
    end else if (settle != 3'd0) begin
      settle <= settle - 3'd1;
    end
  end

  hcck_key_unit u_key (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_wr),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .key_info (key_info)
  );

  hcck_data_path u_data (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (accept),
    .first_char    (first_char),
    .second_char   (second_char),
    .key_info      (key_info),
    .out_valid     (done),
    .first_cipher  (first_cipher),
    .second_cipher (second_cipher),
    .status        (status)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 done) else $error("result did not follow a request after four cycles");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (first_cipher == 8'd0 && second_cipher == 8'd0))
    else $error("error result carries nonzero letters");

  a_ok_letter: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OK) |-> (first_cipher >= LOWER_A && first_cipher <= LOWER_Z &&
      second_cipher >= LOWER_A && second_cipher <= LOWER_Z))
    else $error("ok result is not a lowercase letter pair");

  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> busy) else $error("key write did not hold off requests");
`endif

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for hill_cipher_2x2_cubic_key: directed table, then random key phases.
// Depends on hcck_pkg and the hill_cipher_2x2_cubic_key RTL; results are checked against
// an in-bench predictor of the cube-plus-double key matrix.

module tb;
  import hcck_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES = 12;
  localparam int unsigned PAIRS_PER_PHASE = 85;
  localparam int unsigned DET_BAD_PRIME = 13;

  localparam logic [IDX_W-1:0] REG_SPARE_FIRST = 3'd4;
  localparam logic [IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [CHAR_W-1:0] first;
    logic [CHAR_W-1:0] second;
    status_t           st;
  } cipher_t;

  typedef enum logic {ROW_PAIR, ROW_KEY} row_op_t;

  typedef struct packed {
    row_op_t           op;
    logic [CHAR_W-1:0] a;
    logic [CHAR_W-1:0] b;
    logic              typed;
    cipher_t           res;
  } row_t;

  localparam cipher_t NO_RES       = '{8'h00, 8'h00, ST_OK};
  localparam cipher_t BAD_KEY_RES  = '{8'h00, 8'h00, ST_BAD_KEY};
  localparam cipher_t BAD_CHAR_RES = '{8'h00, 8'h00, ST_BAD_CHAR};
  localparam cipher_t AA_RES       = '{"a", "a", ST_OK};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [CHAR_W-1:0] first_char = '0;
  logic [CHAR_W-1:0] second_char = '0;
  logic cfg_valid = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [LETTER_W-1:0] cfg_data = '0;
  logic busy;
  logic done;
  logic cfg_ready;
  logic [CHAR_W-1:0] first_cipher;
  logic [CHAR_W-1:0] second_cipher;
  status_t status;

  logic [KEY_REGS-1:0][LETTER_W-1:0] key_model = {RST_R1C1, RST_R1C0, RST_R0C1, RST_R0C0};
  cipher_t cipher_due_q [$];
  cipher_t want;
  cipher_t seen;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit calm = 1'b0;

  row_t directed_rows [36] = '{
    '{ROW_PAIR, "a", "a", 1'b1, AA_RES},
    '{ROW_PAIR, "A", "A", 1'b1, AA_RES},
    '{ROW_PAIR, "z", "Z", 1'b0, NO_RES},
    '{ROW_PAIR, "Z", "a", 1'b0, NO_RES},
    '{ROW_PAIR, 8'h00, "a", 1'b1, BAD_CHAR_RES},
    '{ROW_PAIR, "b", 8'hff, 1'b1, BAD_CHAR_RES},
    '{ROW_PAIR, 8'h40, 8'h5b, 1'b1, BAD_CHAR_RES},
    '{ROW_PAIR, 8'h60, 8'h7b, 1'b1, BAD_CHAR_RES},
    '{ROW_PAIR, "m", "N", 1'b0, NO_RES},
    '{ROW_KEY, 8'(REG_R0C0), 8'd0, 1'b0, NO_RES},
    '{ROW_KEY, 8'(REG_R0C1), 8'd0, 1'b0, NO_RES},
    '{ROW_KEY, 8'(REG_R1C1), 8'd0, 1'b0, NO_RES},
    '{ROW_PAIR, "a", "b", 1'b1, BAD_KEY_RES},
    '{ROW_PAIR, 8'h00, 8'hff, 1'b1, BAD_KEY_RES},
    '{ROW_KEY, 8'(REG_R0C0), 8'd25, 1'b0, NO_RES},
    '{ROW_KEY, 8'(REG_R1C1), 8'd25, 1'b0, NO_RES},
    '{ROW_PAIR, "z", "z", 1'b0, NO_RES},
    '{ROW_PAIR, "Q", "e", 1'b0, NO_RES},
    '{ROW_KEY, 8'(REG_R0C0), 8'd31, 1'b0, NO_RES},
    '{ROW_PAIR, "a", "a", 1'b1, BAD_KEY_RES},
    '{ROW_KEY, 8'(REG_R0C0), 8'd25, 1'b0, NO_RES},
    '{ROW_KEY, 8'(REG_SPARE_LAST), 8'd31, 1'b0, NO_RES},
    '{ROW_KEY, 8'(REG_SPARE_FIRST), 8'd0, 1'b0, NO_RES},
    '{ROW_PAIR, "y", "X", 1'b0, NO_RES},
    '{ROW_KEY, 8'(REG_R0C0), 8'd2, 1'b0, NO_RES},
    '{ROW_KEY, 8'(REG_R1C1), 8'd2, 1'b0, NO_RES},
    '{ROW_PAIR, "c", "d", 1'b1, BAD_KEY_RES},
    '{ROW_KEY, 8'(REG_R0C0), 8'd13, 1'b0, NO_RES},
    '{ROW_KEY, 8'(REG_R1C1), 8'd1, 1'b0, NO_RES},
    '{ROW_PAIR, "k", "K", 1'b1, BAD_KEY_RES},
    '{ROW_KEY, 8'(REG_R0C0), 8'd0, 1'b0, NO_RES},
    '{ROW_KEY, 8'(REG_R1C1), 8'd0, 1'b0, NO_RES},
    '{ROW_KEY, 8'(REG_R0C1), 8'd1, 1'b0, NO_RES},
    '{ROW_KEY, 8'(REG_R1C0), 8'd1, 1'b0, NO_RES},
    '{ROW_PAIR, "z", "a", 1'b0, NO_RES},
    '{ROW_PAIR, "A", "z", 1'b0, NO_RES}
  };

  hill_cipher_2x2_cubic_key i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .first_char    (first_char),
    .second_char   (second_char),
    .done          (done),
    .first_cipher  (first_cipher),
    .second_cipher (second_cipher),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic key_admissible(input logic [KEY_REGS-1:0][LETTER_W-1:0] kk);
    int det;
    for (int i = 0; i < KEY_REGS; i++) begin
      if (kk[i] >= MODULUS) return 1'b0;
    end
    det = int'(kk[REG_R0C0[1:0]]) * int'(kk[REG_R1C1[1:0]])
          - int'(kk[REG_R0C1[1:0]]) * int'(kk[REG_R1C0[1:0]]);
    if (det < 0) det = -det;
    return (det % 2 != 0) && (det % int'(DET_BAD_PRIME) != 0);
  endfunction

  function automatic logic letter_code(input logic [CHAR_W-1:0] c, output int unsigned v);
    v = 0;
    if (c >= LOWER_A && c <= LOWER_Z) v = c - LOWER_A;
    else if (c >= UPPER_A && c <= UPPER_Z) v = c - UPPER_A;
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic cipher_t encipher_pair(input logic [KEY_REGS-1:0][LETTER_W-1:0] kk,
                                            input logic [CHAR_W-1:0] c0,
                                            input logic [CHAR_W-1:0] c1);
    cipher_t r;
    int unsigned p0;
    int unsigned p1;
    int unsigned a [2][2];
    int unsigned s [2][2];
    int unsigned e [2][2];
    if (!key_admissible(kk)) return BAD_KEY_RES;
    if (!letter_code(c0, p0) || !letter_code(c1, p1)) return BAD_CHAR_RES;
    a[0][0] = kk[REG_R0C0[1:0]];
    a[0][1] = kk[REG_R0C1[1:0]];
    a[1][0] = kk[REG_R1C0[1:0]];
    a[1][1] = kk[REG_R1C1[1:0]];
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        s[i][j] = (a[i][0] * a[0][j] + a[i][1] * a[1][j]) % MODULUS;
      end
    end
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        e[i][j] = (s[i][0] * a[0][j] + s[i][1] * a[1][j] + 2 * a[i][j]) % MODULUS;
      end
    end
    r.first = 8'((p0 * e[0][0] + p1 * e[1][0]) % MODULUS) + LOWER_A;
    r.second = 8'((p0 * e[0][1] + p1 * e[1][1]) % MODULUS) + LOWER_A;
    r.st = ST_OK;
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] random_char();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return LOWER_A + 8'($urandom_range(0, 25));
    if (roll < 85) return UPPER_A + 8'($urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  // Called at a rising edge; leaves start high unless a random gap follows.
  task automatic send_pair(input logic [CHAR_W-1:0] c0, input logic [CHAR_W-1:0] c1,
                           input logic typed, input cipher_t typed_res);
    start <= 1'b1;
    first_char <= c0;
    second_char <= c1;
    do @(posedge clk); while (busy);
    cipher_due_q.push_back(typed ? typed_res : encipher_pair(key_model, c0, c1));
    if (!calm && $urandom_range(0, 99) < 29) begin
      start <= 1'b0;
      first_char <= 8'($urandom);
      second_char <= 8'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Key writes only go out once every pending request has returned its result.
  task automatic write_key(input logic [IDX_W-1:0] idx, input logic [LETTER_W-1:0] val);
    start <= 1'b0;
    do @(negedge clk); while (cipher_due_q.size() != 0);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < KEY_REGS) key_model[idx[1:0]] = val;
    cfg_valid <= 1'b0;
    cfg_index <= IDX_W'($urandom);
    cfg_data <= LETTER_W'($urandom);
    if (!calm && $urandom_range(0, 99) < 29) repeat ($urandom_range(1, 4)) @(posedge clk);
  endtask

  task automatic load_phase_key(input int unsigned ph);
    logic [KEY_REGS-1:0][LETTER_W-1:0] kk;
    case (ph % 6)
      4: begin
        for (int i = 0; i < KEY_REGS; i++) kk[i] = LETTER_W'($urandom_range(0, 25));
      end
      5: begin
        for (int i = 0; i < KEY_REGS; i++) kk[i] = LETTER_W'($urandom_range(0, 25));
        kk[$urandom_range(0, KEY_REGS - 1)] = LETTER_W'($urandom_range(26, 31));
      end
      default: begin
        do begin
          for (int i = 0; i < KEY_REGS; i++) kk[i] = LETTER_W'($urandom_range(0, 25));
        end while (!key_admissible(kk));
      end
    endcase
    if ($urandom_range(0, 1)) begin
      write_key(IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                LETTER_W'($urandom_range(0, 31)));
    end
    for (int i = 0; i < KEY_REGS; i++) write_key(IDX_W'(i), kk[i]);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("hill_cipher_2x2_cubic_key: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      seen = '{first_cipher, second_cipher, status};
      if (cipher_due_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result %h %h %0d", $time, seen.first, seen.second, seen.st);
      end else begin
        want = cipher_due_q.pop_front();
        if (seen.first !== want.first || seen.second !== want.second || seen.st !== want.st) begin
          fail_count++;
          $display("%0t: expected %h %h %0d, got %h %h %0d", $time,
                   want.first, want.second, want.st, seen.first, seen.second, seen.st);
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_KEY) begin
        write_key(directed_rows[i].a[IDX_W-1:0], directed_rows[i].b[LETTER_W-1:0]);
      end else begin
        send_pair(directed_rows[i].a, directed_rows[i].b, directed_rows[i].typed,
                  directed_rows[i].res);
      end
    end
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      calm = (ph == 3);
      load_phase_key(ph);
      for (int unsigned n = 0; n < PAIRS_PER_PHASE; n++) begin
        send_pair(random_char(), random_char(), 1'b0, NO_RES);
      end
    end
    start <= 1'b0;
    do @(negedge clk); while (cipher_due_q.size() != 0);
    repeat (2 * SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("hill_cipher_2x2_cubic_key: match");
    end else begin
      $display("hill_cipher_2x2_cubic_key: mismatch");
    end
    $finish;
  end

endmodule
